/* rtl/core/srfr_pkg.sv */
// Shared types and constants for the serial register frame receiver.
// Used by the front parser, the command queue, the write-back unit and the top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package srfr_pkg;

  // Frame geometry
  localparam int FRAME_BYTES = 64;
  localparam int FIELD_BYTES = 5;
  localparam int DATA_DEPTH  = FRAME_BYTES - 6;
  localparam logic [7:0] HEADER_BYTE = 8'h5A;

  // Derived widths
  localparam int POS_W  = $clog2(FRAME_BYTES + 1);
  localparam int ADDR_W = $clog2(DATA_DEPTH);
  localparam int CNT_W  = $clog2(DATA_DEPTH + 1);
  localparam int CMP_W  = 10;

  // Command queue depth
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Result event codes
  typedef enum logic [1:0] {
    EV_WRITE = 2'd0,
    EV_EMPTY = 2'd1,
    EV_CSUM  = 2'd2,
    EV_OVER  = 2'd3
  } ev_t;

  // Parser phase
  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_BODY = 2'd1,
    PH_CSUM = 2'd2
  } phase_t;

  // Write-back unit state
  typedef enum logic [1:0] {
    BK_IDLE      = 2'd0,
    BK_READ      = 2'd1,
    BK_WRITE_OUT = 2'd2,
    BK_EVENT_OUT = 2'd3
  } bk_state_t;

  // Frame-end command from parser to write-back unit
  typedef struct packed {
    ev_t              ev;
    logic [7:0]       start;
    logic [CNT_W-1:0] count;
  } cmd_t;

  // Data store write port
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } mem_wr_t;

  // Queue status seen by the parser
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

/* rtl/core/srfr_front.sv */
// Front parser: hunts for the header, tracks fields, checksum and data bytes.
// Writes data bytes into the store and pushes one command per frame end.
// Depends on srfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srfr_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic [7:0]          in_rx_byte,
  output logic                     in_stall,
  input  wire srfr_pkg::q_status_t q_status,
  input  wire logic                burst_pending,
  output logic                     push,
  output srfr_pkg::cmd_t           cmd,
  output srfr_pkg::mem_wr_t        mem_wr
);

  srfr_pkg::phase_t                 phase_r, phase_nxt;
  logic [srfr_pkg::POS_W-1:0]       pos_r, pos_nxt;
  logic [7:0]                       start_r, start_nxt;
  logic [7:0]                       count_r, count_nxt;
  logic [7:0]                       sum_r, sum_nxt;

  logic                             accept;
  logic                             live;
  logic                             over;
  logic                             data_pos;
  logic                             last_data;
  logic [srfr_pkg::POS_W-1:0]       off;

  // Classify the current position
  assign live      = phase_r inside {srfr_pkg::PH_BODY, srfr_pkg::PH_CSUM};
  assign over      = live && (pos_r >= srfr_pkg::POS_W'(srfr_pkg::FRAME_BYTES));
  assign data_pos  = (phase_r == srfr_pkg::PH_BODY) && !over &&
                     (pos_r >= srfr_pkg::POS_W'(srfr_pkg::FIELD_BYTES));
  assign off       = pos_r - srfr_pkg::POS_W'(srfr_pkg::FIELD_BYTES);
  assign last_data = (srfr_pkg::CMP_W'(count_r) + srfr_pkg::CMP_W'(4)) ==
                     srfr_pkg::CMP_W'(pos_r);

  // Hold the byte while the queue is full, or a data byte while a pending burst still reads the store
  assign in_stall = q_status.full || (data_pos && burst_pending);
  assign accept   = in_valid && !in_stall;

  // Next state
  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    start_nxt = start_r;
    count_nxt = count_r;
    sum_nxt   = sum_r;
    if (accept) begin
      case (phase_r)
        srfr_pkg::PH_BODY: begin
          if (over) begin
            phase_nxt = srfr_pkg::PH_HUNT;
            pos_nxt   = '0;
          end else begin
            sum_nxt = sum_r + in_rx_byte;
            if (pos_r == srfr_pkg::POS_W'(3)) begin
              start_nxt = in_rx_byte;
            end else if (pos_r == srfr_pkg::POS_W'(4)) begin
              count_nxt = in_rx_byte;
              if (in_rx_byte == 8'd0) begin
                phase_nxt = srfr_pkg::PH_CSUM;
              end
            end else if (data_pos && last_data) begin
              phase_nxt = srfr_pkg::PH_CSUM;
            end
            pos_nxt = pos_r + srfr_pkg::POS_W'(1);
          end
        end
        srfr_pkg::PH_CSUM: begin
          phase_nxt = srfr_pkg::PH_HUNT;
          pos_nxt   = '0;
        end
        default: begin
          if (in_rx_byte == srfr_pkg::HEADER_BYTE) begin
            phase_nxt = srfr_pkg::PH_BODY;
            pos_nxt   = srfr_pkg::POS_W'(1);
            sum_nxt   = 8'd0;
          end else begin
            phase_nxt = srfr_pkg::PH_HUNT;
            pos_nxt   = '0;
          end
        end
      endcase
    end
  end

  // Outputs: frame-end command and store write
  always_comb begin
    push      = 1'b0;
    cmd.ev    = srfr_pkg::EV_WRITE;
    cmd.start = start_r;
    cmd.count = count_r[srfr_pkg::CNT_W-1:0];
    if (over) begin
      push   = accept;
      cmd.ev = srfr_pkg::EV_OVER;
    end else if (phase_r == srfr_pkg::PH_CSUM) begin
      push = accept;
      if (in_rx_byte != sum_r) begin
        cmd.ev = srfr_pkg::EV_CSUM;
      end else if (count_r == 8'd0) begin
        cmd.ev = srfr_pkg::EV_EMPTY;
      end else begin
        cmd.ev = srfr_pkg::EV_WRITE;
      end
    end
    mem_wr.en   = accept && data_pos && (off < srfr_pkg::POS_W'(srfr_pkg::DATA_DEPTH));
    mem_wr.addr = off[srfr_pkg::ADDR_W-1:0];
    mem_wr.data = in_rx_byte;
  end

  // Advance state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= srfr_pkg::PH_HUNT;
      pos_r   <= '0;
      start_r <= 8'd0;
      count_r <= 8'd0;
      sum_r   <= 8'd0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      start_r <= start_nxt;
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/srfr_cmd_queue.sv */
// Short FIFO of frame-end commands between the parser and the write-back unit.
// Depends on srfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srfr_cmd_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire srfr_pkg::cmd_t push_cmd,
  input  wire logic           pop,
  output srfr_pkg::cmd_t      head,
  output srfr_pkg::q_status_t status
);

  srfr_pkg::cmd_t               slot_r [srfr_pkg::QUEUE_DEPTH];
  logic [srfr_pkg::QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [srfr_pkg::QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [srfr_pkg::QCNT_W-1:0]  fill_r, fill_nxt;

  assign head         = slot_r[rd_ptr_r];
  assign status.full  = (fill_r == srfr_pkg::QCNT_W'(srfr_pkg::QUEUE_DEPTH));
  assign status.empty = (fill_r == '0);

  // Pointer and fill update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == srfr_pkg::QPTR_W'(srfr_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + srfr_pkg::QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == srfr_pkg::QPTR_W'(srfr_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + srfr_pkg::QPTR_W'(1);
    end
    if (push && !pop) begin
      fill_nxt = fill_r + srfr_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - srfr_pkg::QCNT_W'(1);
    end
  end

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/srfr_back.sv */
// Write-back unit: pops frame-end commands, reads the data store and drives results.
// Holds the data store memory and the output register. Depends on srfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srfr_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire srfr_pkg::mem_wr_t mem_wr,
  input  wire srfr_pkg::cmd_t    head,
  input  wire logic              q_empty,
  output logic                   pop,
  output logic                   busy,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [1:0]             out_event_res,
  output logic [8:0]             out_reg_index,
  output logic [7:0]             out_reg_value,
  output logic                   out_last
);

  logic [7:0]                   store [srfr_pkg::DATA_DEPTH];
  logic [7:0]                   rd_data_r;

  srfr_pkg::bk_state_t          st_r, st_nxt;
  srfr_pkg::cmd_t               cur_r;
  logic [srfr_pkg::ADDR_W-1:0]  idx_r;

  logic                         out_valid_r;
  srfr_pkg::ev_t                ev_r;
  logic [8:0]                   index_r;
  logic [7:0]                   value_r;
  logic                         last_r;

  logic                         out_free;
  logic                         load;
  logic                         last_wr;
  srfr_pkg::ev_t                ld_ev;
  logic [8:0]                   ld_index;
  logic [7:0]                   ld_value;
  logic                         ld_last;

  assign out_free = !out_valid_r || !out_stall;
  assign last_wr  = (srfr_pkg::CNT_W'(idx_r) + srfr_pkg::CNT_W'(1)) == cur_r.count;
  assign busy     = (st_r != srfr_pkg::BK_IDLE);

  // Next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      srfr_pkg::BK_IDLE: begin
        if (!q_empty) begin
          st_nxt = (head.ev == srfr_pkg::EV_WRITE) ? srfr_pkg::BK_READ :
                                                     srfr_pkg::BK_EVENT_OUT;
        end
      end
      srfr_pkg::BK_READ: st_nxt = srfr_pkg::BK_WRITE_OUT;
      srfr_pkg::BK_WRITE_OUT: begin
        if (out_free) begin
          st_nxt = last_wr ? srfr_pkg::BK_IDLE : srfr_pkg::BK_READ;
        end
      end
      srfr_pkg::BK_EVENT_OUT: begin
        if (out_free) begin
          st_nxt = srfr_pkg::BK_IDLE;
        end
      end
      default: st_nxt = srfr_pkg::BK_IDLE;
    endcase
  end

  // Outputs: pop and output register load
  always_comb begin
    pop      = 1'b0;
    load     = 1'b0;
    ld_ev    = cur_r.ev;
    ld_index = 9'd0;
    ld_value = 8'd0;
    ld_last  = 1'b1;
    case (st_r)
      srfr_pkg::BK_IDLE: pop = !q_empty;
      srfr_pkg::BK_WRITE_OUT: begin
        load     = out_free;
        ld_ev    = srfr_pkg::EV_WRITE;
        ld_index = {1'b0, cur_r.start} + 9'(idx_r);
        ld_value = rd_data_r;
        ld_last  = last_wr;
      end
      srfr_pkg::BK_EVENT_OUT: load = out_free;
      default: load = 1'b0;
    endcase
  end

  // Data store: one write port from the parser, registered read here
  always_ff @(posedge clk) begin
    if (mem_wr.en) begin
      store[mem_wr.addr] <= mem_wr.data;
    end
    if (st_r == srfr_pkg::BK_READ) begin
      rd_data_r <= store[idx_r];
    end
  end

  // Latch the popped command and step the offset
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= head;
    end
    if (pop) begin
      idx_r <= '0;
    end else if (load && (st_r == srfr_pkg::BK_WRITE_OUT) && !last_wr) begin
      idx_r <= idx_r + srfr_pkg::ADDR_W'(1);
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load) begin
      ev_r    <= ld_ev;
      index_r <= ld_index;
      value_r <= ld_value;
      last_r  <= ld_last;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= srfr_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_event_res = ev_r;
  assign out_reg_index = index_r;
  assign out_reg_value = value_r;
  assign out_last      = last_r;

  // A read is always followed by its result load stage
  a_read_then_load: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == srfr_pkg::BK_READ) |=> (st_r == srfr_pkg::BK_WRITE_OUT))
    else $error("read stage not followed by load stage");

  // A popped write command never carries a zero count
  a_write_count: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && (head.ev == srfr_pkg::EV_WRITE)) |-> (head.count != '0))
    else $error("write burst with zero count");

  // Output register is only loaded when it is free
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (!out_valid_r || !out_stall))
    else $error("output register overwritten");

endmodule

`default_nettype wire

/* rtl/core/serial_register_frame_receiver_unit.sv */
// Serial register frame receiver, top level: parser front, command queue, write-back unit.
// Input: one byte per cycle unless stalled; a byte stalls while the command queue is full,
// and a data byte also while an earlier frame's writes are pending. A frame-end byte's command
// passes the command queue and the write-back state to the output register; a write burst reads the store, then loads.
// Synchronous active-low reset: parser hunts, queue empty, no result valid; store not cleared.
// Depends on srfr_pkg, srfr_front, srfr_cmd_queue and srfr_back.
`timescale 1ns / 1ps
`default_nettype none

module serial_register_frame_receiver_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      out_event_res,
  output logic [8:0]      out_reg_index,
  output logic [7:0]      out_reg_value,
  output logic            out_last
);

  srfr_pkg::q_status_t q_status;
  srfr_pkg::cmd_t      push_cmd;
  srfr_pkg::cmd_t      head;
  srfr_pkg::mem_wr_t   mem_wr;
  logic                push;
  logic                pop;
  logic                back_busy;
  logic                burst_pending;

  // Any queued or active command may still read the store
  assign burst_pending = !q_status.empty || back_busy;

  srfr_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_rx_byte    (in_rx_byte),
    .in_stall      (in_stall),
    .q_status      (q_status),
    .burst_pending (burst_pending),
    .push          (push),
    .cmd           (push_cmd),
    .mem_wr        (mem_wr)
  );

  srfr_cmd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  srfr_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .mem_wr        (mem_wr),
    .head          (head),
    .q_empty       (q_status.empty),
    .pop           (pop),
    .busy          (back_busy),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_event_res (out_event_res),
    .out_reg_index (out_reg_index),
    .out_reg_value (out_reg_value),
    .out_last      (out_last)
  );

  // Store writes never overlap a pending burst
  a_store_hazard: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr.en |-> (q_status.empty && !back_busy))
    else $error("store written while a burst is pending");

  // No push into a full queue
  a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_status.full)
    else $error("command pushed into full queue");

  // No pop from an empty queue
  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_status.empty)
    else $error("command popped from empty queue");

endmodule

`default_nettype wire

/* bench/tb.sv */
// Testbench for serial_register_frame_receiver_unit: directed frame table, then random frames.
// Checks each result against the predictor or a directed row; idles both channels at random.
// Depends on srfr_pkg and the RTL of serial_register_frame_receiver_unit.
`timescale 1ns / 1ps

module tb;
  import srfr_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int TARGET_ITEMS = 380;
  localparam int DRAIN_CYCLES = 20;

  // One expected frame event or register write
  typedef struct packed {
    ev_t        ev;
    logic [8:0] idx;
    logic [7:0] val;
    logic       last;
  } frame_event_t;

  // How a directed row is checked
  typedef enum logic [1:0] {
    CHK_MODEL = 2'd0,
    CHK_NONE  = 2'd1,
    CHK_ONE   = 2'd2
  } row_chk_t;

  typedef struct packed {
    logic [7:0]   rx;
    row_chk_t     chk;
    frame_event_t want;
  } stim_row_t;

  localparam frame_event_t NO_EVENT = '{EV_WRITE, 9'd0, 8'd0, 1'b0};
  localparam int NUM_ROWS = 22;

  // Noise, empty frame at field extremes, two-byte write, bad checksum
  localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{8'h00, CHK_NONE,  NO_EVENT},
    '{8'hFF, CHK_NONE,  NO_EVENT},
    '{8'h5A, CHK_NONE,  NO_EVENT},
    '{8'hFF, CHK_NONE,  NO_EVENT},
    '{8'h00, CHK_NONE,  NO_EVENT},
    '{8'hFF, CHK_NONE,  NO_EVENT},
    '{8'h00, CHK_NONE,  NO_EVENT},
    '{8'hFE, CHK_ONE,   '{EV_EMPTY, 9'd0, 8'd0, 1'b1}},
    '{8'h5A, CHK_NONE,  NO_EVENT},
    '{8'h01, CHK_NONE,  NO_EVENT},
    '{8'h10, CHK_NONE,  NO_EVENT},
    '{8'hFE, CHK_NONE,  NO_EVENT},
    '{8'h02, CHK_NONE,  NO_EVENT},
    '{8'hFF, CHK_NONE,  NO_EVENT},
    '{8'h00, CHK_NONE,  NO_EVENT},
    '{8'h10, CHK_MODEL, NO_EVENT},
    '{8'h5A, CHK_NONE,  NO_EVENT},
    '{8'h00, CHK_NONE,  NO_EVENT},
    '{8'h00, CHK_NONE,  NO_EVENT},
    '{8'h00, CHK_NONE,  NO_EVENT},
    '{8'h00, CHK_NONE,  NO_EVENT},
    '{8'h01, CHK_ONE,   '{EV_CSUM, 9'd0, 8'd0, 1'b1}}
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_event_res;
  logic [8:0] out_reg_index;
  logic [7:0] out_reg_value;
  logic       out_last;

  // Predictor state
  phase_t      rx_phase;
  int unsigned rx_pos;
  logic [7:0]  rx_start;
  logic [7:0]  rx_count;
  logic [7:0]  rx_sum;
  logic [7:0]  rx_store [DATA_DEPTH];

  frame_event_t byte_events [$];
  frame_event_t awaited_events [$];

  int  mismatches = 0;
  int  items_sent = 0;
  int  cycle_count = 0;
  int  hold_left = 0;
  bit  send_quiet = 1'b0;
  bit  drain_quiet = 1'b0;
  frame_event_t got_event;

  serial_register_frame_receiver_unit i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_rx_byte    (in_rx_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_event_res (out_event_res),
    .out_reg_index (out_reg_index),
    .out_reg_value (out_reg_value),
    .out_last      (out_last)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Advance the frame predictor by one byte; leave its events in byte_events
  task automatic predict_rx_byte(input logic [7:0] b);
    int unsigned off;
    frame_event_t ev_item;
    byte_events.delete();
    if (rx_phase != PH_BODY && rx_phase != PH_CSUM) begin
      // hunt: only the header opens a frame
      if (b == HEADER_BYTE) begin
        rx_phase = PH_BODY;
        rx_pos = 1;
        rx_sum = 8'h00;
      end else begin
        rx_phase = PH_HUNT;
        rx_pos = 0;
      end
    end else if (rx_pos >= FRAME_BYTES) begin
      // too long for the buffer: drop the byte and hunt again
      byte_events.push_back('{EV_OVER, 9'd0, 8'd0, 1'b1});
      rx_phase = PH_HUNT;
      rx_pos = 0;
    end else if (rx_phase == PH_BODY) begin
      rx_sum = rx_sum + b;
      if (rx_pos == 3) begin
        rx_start = b;
      end else if (rx_pos == 4) begin
        rx_count = b;
        if (b == 8'h00) rx_phase = PH_CSUM;
      end else if (rx_pos >= FIELD_BYTES) begin
        off = rx_pos - FIELD_BYTES;
        if (off < DATA_DEPTH) rx_store[off] = b;
        if (rx_pos == 4 + rx_count) rx_phase = PH_CSUM;
      end
      rx_pos++;
    end else begin
      // checksum byte closes the frame
      if (b != rx_sum) begin
        byte_events.push_back('{EV_CSUM, 9'd0, 8'd0, 1'b1});
      end else if (rx_count == 8'h00) begin
        byte_events.push_back('{EV_EMPTY, 9'd0, 8'd0, 1'b1});
      end else begin
        for (int i = 0; i < rx_count && i < DATA_DEPTH; i++) begin
          ev_item.ev = EV_WRITE;
          ev_item.idx = {1'b0, rx_start} + 9'(i);
          ev_item.val = rx_store[i];
          ev_item.last = (i + 1 == rx_count);
          byte_events.push_back(ev_item);
        end
      end
      rx_phase = PH_HUNT;
      rx_pos = 0;
    end
  endtask

  // Offer one byte after a random gap, hold it until accepted, then predict
  task automatic send_rx_byte(input logic [7:0] b, input row_chk_t chk,
                              input frame_event_t want);
    int gap;
    if ($urandom_range(0, 31) == 0) send_quiet = !send_quiet;
    gap = send_quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    items_sent++;
    predict_rx_byte(b);
    case (chk)
      CHK_MODEL: foreach (byte_events[k]) awaited_events.push_back(byte_events[k]);
      CHK_ONE:   awaited_events.push_back(want);
      default:   ;
    endcase
  endtask

  // Build one frame with random content; some are cut short or carry a bad checksum
  task automatic send_random_frame(input int frame_no);
    logic [7:0] frame_bytes [$];
    logic [7:0] id_b, func_b, start_b, count_b, sum;
    int n_data, limit;
    repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0)
      send_rx_byte(8'($urandom_range(0, 255)), CHK_MODEL, NO_EVENT);
    id_b = 8'($urandom_range(0, 255));
    func_b = 8'($urandom_range(0, 255));
    start_b = 8'($urandom_range(0, 255));
    if (frame_no == 3) begin
      count_b = 8'(DATA_DEPTH);
      start_b = 8'hFF;
    end else if (frame_no == 9) begin
      count_b = 8'($urandom_range(DATA_DEPTH + 1, 255));
    end else if ($urandom_range(0, 7) == 0) begin
      count_b = 8'($urandom_range(7, 20));
    end else begin
      count_b = 8'($urandom_range(0, 6));
    end
    // an overflowing frame needs only enough data to reach the end of the buffer
    n_data = (count_b > DATA_DEPTH + 1) ? DATA_DEPTH + 1 : count_b;
    frame_bytes = '{HEADER_BYTE, id_b, func_b, start_b, count_b};
    sum = id_b + func_b + start_b + count_b;
    repeat (n_data) begin
      frame_bytes.push_back(8'($urandom_range(0, 255)));
      sum = sum + frame_bytes[$];
    end
    if ($urandom_range(0, 4) == 0) sum = sum ^ 8'($urandom_range(1, 255));
    frame_bytes.push_back(sum);
    limit = frame_bytes.size();
    if ($urandom_range(0, 9) == 0) limit = $urandom_range(1, limit - 1);
    for (int k = 0; k < limit; k++) send_rx_byte(frame_bytes[k], CHK_MODEL, NO_EVENT);
  endtask

  // Stimulus: reset, directed table, random frames, drain
  initial begin
    int frame_no;
    rx_phase = PH_HUNT;
    rx_pos = 0;
    rx_start = 8'h00;
    rx_count = 8'h00;
    rx_sum = 8'h00;
    foreach (rx_store[k]) rx_store[k] = 8'h00;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    for (int r = 0; r < NUM_ROWS; r++)
      send_rx_byte(DIRECTED_ROWS[r].rx, DIRECTED_ROWS[r].chk, DIRECTED_ROWS[r].want);
    frame_no = 0;
    while (items_sent < TARGET_ITEMS) begin
      send_random_frame(frame_no);
      frame_no++;
    end
    in_valid <= 1'b0;
    while (awaited_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Check each accepted transaction, then draw the stall before the next
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_events.size() == 0) begin
        report_mismatch($sformatf("unexpected ev=%0d idx=%0d val=%0d last=%0d",
                                  out_event_res, out_reg_index, out_reg_value, out_last));
      end else begin
        got_event = awaited_events.pop_front();
        if (out_event_res !== got_event.ev || out_reg_index !== got_event.idx ||
            out_reg_value !== got_event.val || out_last !== got_event.last)
          report_mismatch($sformatf(
            "got ev=%0d idx=%0d val=%0d last=%0d, want ev=%0d idx=%0d val=%0d last=%0d",
            out_event_res, out_reg_index, out_reg_value, out_last,
            got_event.ev, got_event.idx, got_event.val, got_event.last));
      end
      if ($urandom_range(0, 31) == 0) drain_quiet = !drain_quiet;
      hold_left = drain_quiet ? 0 : $urandom_range(0, 3);
    end else if (hold_left > 0) begin
      hold_left--;
    end
    out_stall <= (hold_left != 0);
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

endmodule
